// ----- hw/rtl/elx_pkg.sv -----
// ----------------------------------------------------------------------------
// elx_pkg: shared types and constants for the expression lexer
// Token kinds, lexer modes, character codes and the token records that pass
// between the front end, the token queue and the output stage.
// ----------------------------------------------------------------------------
package elx_pkg;

  // State widths
  localparam int POSITION_BITS = 32;
  localparam int LENGTH_BITS   = 16;

  // Result field widths
  localparam int START_W   = 32;
  localparam int LEN_OUT_W = 16;

  // Token queue depth (pair entries)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_ASSIGN  = 8'h3D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;

  typedef enum logic [3:0] {
    KIND_NUM     = 4'd0,
    KIND_IDENT   = 4'd1,
    KIND_PLUS    = 4'd2,
    KIND_MINUS   = 4'd3,
    KIND_MUL     = 4'd4,
    KIND_DIV     = 4'd5,
    KIND_LPAREN  = 4'd6,
    KIND_RPAREN  = 4'd7,
    KIND_SEMI    = 4'd8,
    KIND_ASSIGN  = 4'd9,
    KIND_END     = 4'd10,
    KIND_UNKNOWN = 4'd11
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NUM     = 3'd1,
    MODE_IDENT   = 3'd2,
    MODE_SLASH   = 3'd3,
    MODE_COMMENT = 3'd4
  } mode_t;

  typedef struct packed {
    kind_t                 kind;
    logic [START_W-1:0]    start;
    logic [LEN_OUT_W-1:0]  length;
  } tok_t;

  // One or two tokens caused by one input beat
  typedef struct packed {
    tok_t first;
    tok_t second;
    logic two;
  } pair_t;

  function automatic kind_t single_kind(logic [7:0] c);
    kind_t k;
    case (c)
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_MUL;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_SEMI:   k = KIND_SEMI;
      CH_ASSIGN: k = KIND_ASSIGN;
      default:   k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// ----- hw/rtl/elx_if.sv -----
// ----------------------------------------------------------------------------
// elx_if: lexer channel interfaces
// Valid/ready channels for source bytes in and tokens out.
// ----------------------------------------------------------------------------
interface elx_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] char_byte;

  modport source (output valid, output opcode, output char_byte, input ready);
  modport sink   (input valid, input opcode, input char_byte, output ready);
endinterface

interface elx_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [31:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input last_of_run, output ready);
endinterface

// ----- hw/rtl/elx_front.sv -----
// ----------------------------------------------------------------------------
// elx_front: lexer front end
// Holds the lexer mode and open token, classifies each byte and pushes the
// tokens each byte produces into the queue as one pair entry.
// ----------------------------------------------------------------------------
module elx_front (
  input  logic              clk,
  input  logic              rst_n,
  elx_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              q_push,
  output elx_pkg::pair_t    q_pair
);
  import elx_pkg::*;

  mode_t                    mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [LENGTH_BITS-1:0]   len_r, len_nxt;

  logic       fire;
  logic [7:0] c;
  logic       is_digit, is_alpha, is_space;
  logic       lead_valid, tail_valid, run_idle;
  tok_t       lead_tok, tail_tok;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign c           = in_ch.char_byte;

  assign is_digit = c inside {[8'h30:8'h39]};
  assign is_alpha = c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  assign is_space = c inside {8'h20, [8'h09:8'h0D]};

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r + POSITION_BITS'(1);
    start_nxt  = start_r;
    len_nxt    = len_r;
    lead_valid = 1'b0;
    tail_valid = 1'b0;
    run_idle   = 1'b0;
    lead_tok.kind   = (mode_r == MODE_NUM) ? KIND_NUM :
                      (mode_r == MODE_IDENT) ? KIND_IDENT : KIND_DIV;
    lead_tok.start  = START_W'(start_r);
    lead_tok.length = LEN_OUT_W'(len_r);
    tail_tok.kind   = single_kind(c);
    tail_tok.start  = START_W'(pos_r);
    tail_tok.length = LEN_OUT_W'(1);

    if (in_ch.opcode) begin
      // end of text: flush open token, then END, then back to reset state
      lead_valid = (mode_r == MODE_NUM) || (mode_r == MODE_IDENT) ||
                   (mode_r == MODE_SLASH);
      tail_valid      = 1'b1;
      tail_tok.kind   = KIND_END;
      tail_tok.length = '0;
      mode_nxt  = MODE_IDLE;
      pos_nxt   = '0;
      start_nxt = '0;
      len_nxt   = '0;
    end else begin
      case (mode_r)
        MODE_NUM, MODE_IDENT: begin
          if (is_digit || ((mode_r == MODE_IDENT) && is_alpha)) begin
            if (len_r != '1) len_nxt = len_r + LENGTH_BITS'(1);
          end else begin
            lead_valid = 1'b1;
            mode_nxt   = MODE_IDLE;
            len_nxt    = '0;
            run_idle   = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            mode_nxt = MODE_COMMENT;
            len_nxt  = '0;
          end else begin
            lead_valid      = 1'b1;
            lead_tok.length = LEN_OUT_W'(1);
            mode_nxt        = MODE_IDLE;
            len_nxt         = '0;
            run_idle        = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (c == CH_NEWLINE) mode_nxt = MODE_IDLE;
        end
        default: begin
          mode_nxt = MODE_IDLE;
          run_idle = 1'b1;
        end
      endcase

      if (run_idle && !is_space) begin
        if (is_digit || is_alpha || (c == CH_SLASH)) begin
          mode_nxt  = is_digit ? MODE_NUM : (is_alpha ? MODE_IDENT : MODE_SLASH);
          start_nxt = pos_r;
          len_nxt   = LENGTH_BITS'(1);
        end else begin
          tail_valid = 1'b1;
        end
      end
    end
  end

  assign q_push        = fire && (lead_valid || tail_valid);
  assign q_pair.first  = lead_valid ? lead_tok : tail_tok;
  assign q_pair.second = tail_tok;
  assign q_pair.two    = lead_valid && tail_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
    end
  end

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_ch.opcode |=> mode_r == MODE_IDLE && pos_r == '0)
    else $error("lexer state not cleared after end of text");

  a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_ch.opcode |-> q_push)
    else $error("end of text produced no token");

  a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_NUM || mode_r == MODE_IDENT || mode_r == MODE_SLASH)
      |-> len_r != '0)
    else $error("open token with zero length");
endmodule

// ----- hw/rtl/elx_queue.sv -----
// ----------------------------------------------------------------------------
// elx_queue: token pair queue
// Small FIFO of pair entries decoupling the front end from the output stage.
// ----------------------------------------------------------------------------
module elx_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  elx_pkg::pair_t    push_pair,
  output logic              full,
  input  logic              pop,
  output elx_pkg::pair_t    head_pair,
  output logic              empty
);
  import elx_pkg::*;

  pair_t             slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign head_pair = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_pair;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full token queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty token queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("token queue count out of range");
endmodule

// ----- hw/rtl/elx_back.sv -----
// ----------------------------------------------------------------------------
// elx_back: token output stage
// Pops pair entries, sends their tokens one beat at a time from an output
// register and marks the last token of each pair.
// ----------------------------------------------------------------------------
module elx_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  elx_pkg::pair_t    q_head,
  output logic              q_pop,
  elx_out_if.source         out_ch
);
  import elx_pkg::*;

  logic  out_valid_r, out_valid_nxt;
  tok_t  out_tok_r, out_tok_nxt;
  logic  out_last_r, out_last_nxt;
  logic  sec_valid_r, sec_valid_nxt;
  tok_t  sec_tok_r, sec_tok_nxt;
  logic  advance;

  // output register free or being emptied this cycle
  assign advance = !out_valid_r || out_ch.ready;
  assign q_pop   = advance && !sec_valid_r && !q_empty;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_tok_nxt   = out_tok_r;
    out_last_nxt  = out_last_r;
    sec_valid_nxt = sec_valid_r;
    sec_tok_nxt   = sec_tok_r;
    if (advance) begin
      if (sec_valid_r) begin
        out_valid_nxt = 1'b1;
        out_tok_nxt   = sec_tok_r;
        out_last_nxt  = 1'b1;
        sec_valid_nxt = 1'b0;
      end else if (!q_empty) begin
        out_valid_nxt = 1'b1;
        out_tok_nxt   = q_head.first;
        out_last_nxt  = !q_head.two;
        sec_valid_nxt = q_head.two;
        sec_tok_nxt   = q_head.second;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sec_valid_r <= sec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tok_r  <= out_tok_nxt;
    out_last_r <= out_last_nxt;
    sec_tok_r  <= sec_tok_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.token_kind   = out_tok_r.kind;
  assign out_ch.token_start  = out_tok_r.start;
  assign out_ch.token_length = out_tok_r.length;
  assign out_ch.last_of_run  = out_last_r;

  a_second_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
    sec_valid_r |-> out_valid_r && !out_last_r)
    else $error("held second token without a first token in flight");

  a_second_closes: assert property (@(posedge clk) disable iff (!rst_n)
    sec_valid_r && out_ch.ready |=> out_valid_r && out_last_r)
    else $error("second token not sent as last of run");
endmodule

// ----- hw/rtl/expression_lexer_top.sv -----
// ----------------------------------------------------------------------------
// expression_lexer_top: byte-stream lexer for a small arithmetic language
// Path: the first token of a byte passes a queue slot, then the output register.
// Throughput: one byte per cycle unless the token queue is full; a byte that closes
//   a token and emits one too needs two output beats; the output register sets the pace.
// Reset: synchronous active-low rst_n clears mode, position, queue and output.
// ----------------------------------------------------------------------------
module expression_lexer_top (
  input  logic       clk,
  input  logic       rst_n,
  elx_in_if.sink     in_ch,
  elx_out_if.source  out_ch
);
  import elx_pkg::*;

  // Front end -> queue. A byte makes at most two tokens; they travel as one
  // pair entry so the front end pushes at most once per beat.
  logic  q_push;
  pair_t q_push_pair;
  logic  q_full;

  // Queue -> output stage
  logic  q_pop;
  pair_t q_head;
  logic  q_empty;

  // Front end: mode tracking and classification. Ready only depends on
  // queue space, so bytes with no result (whitespace, comment text, digits
  // of an open number) keep flowing while the output side is stalled, until the queue fills.
  elx_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_pair (q_push_pair)
  );

  // Four-entry pair FIFO between the two halves
  elx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_pair (q_push_pair),
    .full      (q_full),
    .pop       (q_pop),
    .head_pair (q_head),
    .empty     (q_empty)
  );

  // Output stage: serializes pairs, one token per beat, marks last_of_run
  elx_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );
endmodule
